FILE: design/pwmca_pkg.sv
// Shared constants, types and helper functions of the PWM channel pair allocator.
package pwmca_pkg;

  // Sizing of the channel set and the duty scale
  localparam int NUM_CHANNELS = 16;
  localparam int DUTY_BITS    = 10;
  localparam int MAX_PIN      = 33;

  localparam int NUM_PAIRS = (NUM_CHANNELS + 1) / 2;
  localparam int CH_W      = $clog2(NUM_CHANNELS);
  localparam int PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int CNT_W     = $clog2(NUM_CHANNELS + 1);
  localparam int PIN_W     = $clog2(MAX_PIN + 1);

  // Fixed field widths of the channels
  localparam int CMD_W     = 1;
  localparam int PIN_IN_W  = 8;
  localparam int FREQ_W    = 32;
  localparam int LEVEL_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int CHAN_W    = 4;
  localparam int DUTY_W    = 10;

  localparam logic [FREQ_W-1:0]  RESET_FREQ = FREQ_W'(1000);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(255);

  typedef enum logic [CMD_W-1:0] {
    CMD_SETUP = 1'b0,
    CMD_DUTY  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_PIN = 2'd1,
    ST_NO_CHAN = 2'd2
  } status_e;

  // One command as taken from the input channel (level goes to the duty scaler)
  typedef struct packed {
    cmd_e                cmd;
    logic [PIN_IN_W-1:0] pin;
    logic [FREQ_W-1:0]   freq;
  } item_t;

  // Outcome of one command, handed from the sequencer to the output stage
  typedef struct packed {
    status_e           status;
    logic [CH_W-1:0]   channel;
    logic              timer_setup;
    logic [FREQ_W-1:0] timer_freq;
    logic              released;
    logic [CH_W-1:0]   released_channel;
  } result_t;

  // Pair number of a channel.
  function automatic logic [PAIR_W-1:0] pair_of(input logic [CH_W-1:0] ch);
    return PAIR_W'(ch >> 1);
  endfunction

endpackage

FILE: design/pwmca_if.sv
// Handshake channels of the PWM channel pair allocator: command, result and configuration.
interface pwmca_item_if
  import pwmca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [PIN_IN_W-1:0] pin;
  logic [FREQ_W-1:0]   freq;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, output cmd, output pin, output freq, output level,
                  input ready);
  modport sink   (input valid, input cmd, input pin, input freq, input level,
                  output ready);
endinterface

interface pwmca_result_if
  import pwmca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHAN_W-1:0]   channel;
  logic [DUTY_W-1:0]   duty;
  logic                timer_setup;
  logic [FREQ_W-1:0]   timer_freq;
  logic                released;
  logic [CHAN_W-1:0]   released_channel;

  modport source (output valid, output status, output channel, output duty,
                  output timer_setup, output timer_freq, output released,
                  output released_channel, input ready);
  modport sink   (input valid, input status, input channel, input duty,
                  input timer_setup, input timer_freq, input released,
                  input released_channel, output ready);
endinterface

interface pwmca_cfg_if
  import pwmca_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pwm_channel_pair_allocator_unit.sv
// Top level of the PWM channel pair allocator: channels, configuration register, output stage.
// A valid pin is scanned through the owner memory one entry per cycle, then passes the
// decide state, a release write when a setup also releases a channel, and the new write.
// An invalid pin goes straight from acceptance to the done state that holds its result.
// Throughput: one command at a time; the next beat is taken the cycle after the result
// enters the output register. Reset clears all owners and pair frequencies at once and
// sets default_freq to 1000.
module pwm_channel_pair_allocator_unit
  import pwmca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pwmca_item_if.sink            item_i,
  pwmca_result_if.source        result_o,
  pwmca_cfg_if.sink             cfg_i
);

  logic [FREQ_W-1:0]    dflt_freq_q;
  logic                 start, idle, done, ack;
  item_t                item;
  result_t              res;
  logic [DUTY_BITS-1:0] duty;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [CHAN_W-1:0]    out_channel_q;
  logic [DUTY_W-1:0]    out_duty_q;
  logic                 out_setup_q;
  logic [FREQ_W-1:0]    out_freq_q;
  logic                 out_rel_q;
  logic [CHAN_W-1:0]    out_rel_ch_q;

  // Configuration register is always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_freq_q <= RESET_FREQ;
    end else if (cfg_i.valid) begin
      dflt_freq_q <= cfg_i.data;
    end
  end

  // Command beat goes to the sequencer whenever it is idle.
  assign item_i.ready = idle;
  assign start        = item_i.valid && idle;
  assign item.cmd     = cmd_e'(item_i.cmd);
  assign item.pin     = item_i.pin;
  assign item.freq    = item_i.freq;

  pwmca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .dflt_freq_i (dflt_freq_q),
    .idle_o      (idle),
    .done_o      (done),
    .result_o    (res),
    .ack_i       (ack)
  );

  pwmca_duty u_duty (
    .clk_i   (clk_i),
    .load_i  (start),
    .level_i (item_i.level),
    .duty_o  (duty)
  );

  // Output register: loads when empty or when its beat is being taken.
  assign ack = done && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_status_q  <= res.status;
      out_channel_q <= CHAN_W'(res.channel);
      out_duty_q    <= (res.status == ST_OK) ? DUTY_W'(duty) : '0;
      out_setup_q   <= res.timer_setup;
      out_freq_q    <= res.timer_freq;
      out_rel_q     <= res.released;
      out_rel_ch_q  <= CHAN_W'(res.released_channel);
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.status           = out_status_q;
  assign result_o.channel          = out_channel_q;
  assign result_o.duty             = out_duty_q;
  assign result_o.timer_setup      = out_setup_q;
  assign result_o.timer_freq       = out_freq_q;
  assign result_o.released         = out_rel_q;
  assign result_o.released_channel = out_rel_ch_q;

endmodule

FILE: design/pwmca_ram.sv
// Single-port-write, single-port-read RAM with registered read data and per-entry valid bits.
module pwmca_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                        wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rdata_q;

  // Storage array; no reset, an entry counts only once its valid bit is set.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Valid bits are cleared at once by reset, so every entry reads as zero until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pwmca_duty.sv
// Duty scaler: level * (2^DUTY_BITS - 1) / 255 by reciprocal multiply and one correction.
module pwmca_duty
  import pwmca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic [LEVEL_W-1:0]   level_i,
  output logic [DUTY_BITS-1:0] duty_o
);

  localparam int XW          = LEVEL_W + DUTY_BITS;
  localparam int RECIP_SHIFT = 2 * LEVEL_W;
  localparam int YW          = XW + LEVEL_W + 1;
  localparam int QW          = YW - RECIP_SHIFT;

  logic [LEVEL_W-1:0] level_q;
  logic [XW-1:0]      prod;
  logic [YW-1:0]      recip;
  logic [QW-1:0]      qest_d;
  logic [QW-1:0]      qest_q;
  logic [XW-1:0]      rem;
  logic               bump;

  // Product with the full-scale duty is a shift and a subtract.
  assign prod   = (XW'(level_q) << DUTY_BITS) - XW'(level_q);
  // 1/255 is approximated by 257/65536; the estimate is exact or one low.
  assign recip  = (YW'(prod) << LEVEL_W) + YW'(prod);
  assign qest_d = recip[YW-1:RECIP_SHIFT];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      level_q <= level_i;
    end
    qest_q <= qest_d;
  end

  // Remainder check lifts a low estimate by one.
  assign rem    = prod - ((XW'(qest_q) << LEVEL_W) - XW'(qest_q));
  assign bump   = (rem >= XW'(LEVEL_FULL));
  assign duty_o = DUTY_BITS'(qest_q + QW'(bump));

endmodule

FILE: design/pwmca_ctrl.sv
// Allocation sequencer: scans the owner and pair frequency memories, decides and writes back.
module pwmca_ctrl
  import pwmca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  item_t             item_i,
  input  logic [FREQ_W-1:0] dflt_freq_i,
  output logic              idle_o,
  output logic              done_o,
  output result_t           result_o,
  input  logic              ack_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_WR_REL = 6'b001000,
    S_WR_NEW = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_CHANNELS);

  state_e state_q, state_d;

  // Scan control
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CH_W-1:0]  rd_ch_q, rd_ch_d;

  // Findings of the scan
  logic keep_q, keep_d, rel_q, rel_d, m1_q, m1_d, m2_q, m2_d, sp_q, sp_d;
  logic alloc_q, alloc_d, fresh_q, fresh_d;

  // Payload held for the current command
  cmd_e              cmd_q;
  logic [PIN_W-1:0]  pin_q;
  logic [FREQ_W-1:0] freq_q;
  logic [PIN_W-1:0]  even_owner_q;
  logic [CH_W-1:0]   own_ch_q, rel_ch_q, m1_ch_q, m2_ch_q, sp_ch_q;
  logic [FREQ_W-1:0] own_pf_q;
  result_t           res_q, res_d;

  // Memory ports
  logic              own_re, own_we;
  logic [CH_W-1:0]   own_raddr, own_waddr;
  logic [PIN_W-1:0]  own_wdata, own_rdata;
  logic              pf_re, pf_we;
  logic [PAIR_W-1:0] pf_raddr, pf_waddr;
  logic [FREQ_W-1:0] pf_rdata;

  // Pair evaluation
  logic              eval, last_eval, pin_bad;
  logic [PIN_W-1:0]  o0, o1;
  logic              exist1, mine0, mine1, drop;
  logic              busy0, busy1, free0, free1, hit, spare;
  logic [CH_W-1:0]   ch0, ch1, hit_ch;

  pwmca_ram #(
    .DATA_W (PIN_W),
    .DEPTH  (NUM_CHANNELS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (own_re),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  pwmca_ram #(
    .DATA_W (FREQ_W),
    .DEPTH  (NUM_PAIRS)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pf_we),
    .waddr_i (pf_waddr),
    .wdata_i (res_q.timer_freq),
    .re_i    (pf_re),
    .raddr_i (pf_raddr),
    .rdata_o (pf_rdata)
  );

  assign pin_bad = (item_i.pin == '0) || (item_i.pin > PIN_IN_W'(MAX_PIN));

  // Reads: one owner entry per cycle, the pair frequency on each even channel.
  assign own_re    = (state_q == S_SCAN) && (cnt_q < CNT_END);
  assign own_raddr = cnt_q[CH_W-1:0];
  assign pf_re     = own_re && !cnt_q[0];
  assign pf_raddr  = pair_of(cnt_q[CH_W-1:0]);

  // Writes happen only after the scan, so reads and writes never overlap.
  assign own_we    = (state_q == S_WR_REL) || ((state_q == S_WR_NEW) && alloc_q);
  assign own_waddr = (state_q == S_WR_REL) ? rel_ch_q : res_q.channel;
  assign own_wdata = (state_q == S_WR_REL) ? '0 : pin_q;
  assign pf_we     = (state_q == S_WR_NEW) && fresh_q;
  assign pf_waddr  = pair_of(res_q.channel);

  // A pair is judged when its odd channel arrives, or at an unpaired last channel.
  assign eval      = rd_vld_q && (rd_ch_q[0] || (rd_ch_q == LAST_CH));
  assign last_eval = rd_vld_q && (rd_ch_q == LAST_CH);
  assign exist1    = rd_ch_q[0];
  assign o0        = exist1 ? even_owner_q : own_rdata;
  assign o1        = exist1 ? own_rdata : '0;
  assign ch0       = rd_ch_q & ~CH_W'(1);
  assign ch1       = rd_ch_q | CH_W'(1);

  // The pin's own channel counts as free when a setup moves it to another frequency.
  assign mine0  = (o0 == pin_q);
  assign mine1  = exist1 && (o1 == pin_q);
  assign drop   = (cmd_q == CMD_SETUP) && (pf_rdata != freq_q);
  assign busy0  = (o0 != '0) && !(mine0 && drop);
  assign busy1  = exist1 && (o1 != '0) && !(mine1 && drop);
  assign free0  = !busy0;
  assign free1  = exist1 && !busy1;
  assign hit    = (free0 && busy1) || (free1 && busy0);
  assign hit_ch = free0 ? ch0 : ch1;
  assign spare  = free0 && !busy1;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rd_vld_d = own_re;
    rd_ch_d  = cnt_q[CH_W-1:0];
    keep_d   = keep_q;
    rel_d    = rel_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    sp_d     = sp_q;
    alloc_d  = alloc_q;
    fresh_d  = fresh_q;
    res_d    = res_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          keep_d  = 1'b0;
          rel_d   = 1'b0;
          m1_d    = 1'b0;
          m2_d    = 1'b0;
          sp_d    = 1'b0;
          alloc_d = 1'b0;
          fresh_d = 1'b0;
          res_d   = '0;
          if (pin_bad) begin
            res_d.status = ST_BAD_PIN;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (own_re) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (eval) begin
          if (mine0 || mine1) begin
            if (drop) begin
              rel_d = 1'b1;
            end else begin
              keep_d = 1'b1;
            end
          end
          if (hit && (pf_rdata == freq_q) && !m1_q) begin
            m1_d = 1'b1;
          end
          if (hit && (pf_rdata == dflt_freq_i) && !m2_q) begin
            m2_d = 1'b1;
          end
          if (spare && !sp_q) begin
            sp_d = 1'b1;
          end
        end
        if (last_eval) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d.status           = ST_OK;
        res_d.released         = rel_q;
        res_d.released_channel = rel_q ? rel_ch_q : '0;
        if (keep_q) begin
          res_d.channel    = own_ch_q;
          res_d.timer_freq = own_pf_q;
        end else if ((cmd_q == CMD_SETUP) && m1_q) begin
          res_d.channel    = m1_ch_q;
          res_d.timer_freq = freq_q;
          alloc_d          = 1'b1;
        end else if ((cmd_q == CMD_DUTY) && m2_q) begin
          // A duty write joins a matching half-used pair before opening a free one.
          res_d.channel    = m2_ch_q;
          res_d.timer_freq = dflt_freq_i;
          alloc_d          = 1'b1;
        end else if (sp_q) begin
          // A fully free pair is set up at the frequency of the first attempt.
          res_d.channel     = sp_ch_q;
          res_d.timer_freq  = (cmd_q == CMD_SETUP) ? freq_q : dflt_freq_i;
          res_d.timer_setup = 1'b1;
          alloc_d           = 1'b1;
          fresh_d           = 1'b1;
        end else if (m2_q) begin
          res_d.channel    = m2_ch_q;
          res_d.timer_freq = dflt_freq_i;
          alloc_d          = 1'b1;
        end else begin
          res_d.status     = ST_NO_CHAN;
          res_d.channel    = '0;
          res_d.timer_freq = '0;
        end
        state_d = rel_q ? S_WR_REL : S_WR_NEW;
      end
      S_WR_REL: begin
        state_d = S_WR_NEW;
      end
      S_WR_NEW: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      keep_q   <= 1'b0;
      rel_q    <= 1'b0;
      m1_q     <= 1'b0;
      m2_q     <= 1'b0;
      sp_q     <= 1'b0;
      alloc_q  <= 1'b0;
      fresh_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      keep_q   <= keep_d;
      rel_q    <= rel_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      sp_q     <= sp_d;
      alloc_q  <= alloc_d;
      fresh_q  <= fresh_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_ch_q <= rd_ch_d;
    res_q   <= res_d;
    if ((state_q == S_IDLE) && start_i) begin
      cmd_q  <= item_i.cmd;
      pin_q  <= PIN_W'(item_i.pin);
      freq_q <= item_i.freq;
    end
    if (rd_vld_q && !rd_ch_q[0]) begin
      even_owner_q <= own_rdata;
    end
    if (eval && (mine0 || mine1)) begin
      if (drop) begin
        rel_ch_q <= mine0 ? ch0 : ch1;
      end else begin
        own_ch_q <= mine0 ? ch0 : ch1;
        own_pf_q <= pf_rdata;
      end
    end
    if (eval && hit && (pf_rdata == freq_q) && !m1_q) begin
      m1_ch_q <= hit_ch;
    end
    if (eval && hit && (pf_rdata == dflt_freq_i) && !m2_q) begin
      m2_ch_q <= hit_ch;
    end
    if (eval && spare && !sp_q) begin
      sp_ch_q <= ch0;
    end
  end

  assign idle_o   = (state_q == S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign result_o = res_q;

endmodule

FILE: test/pwm_channel_pair_allocator_unit_test.sv
// Self-checking testbench of the PWM channel pair allocator, with its own channel binding model.
`timescale 1ns / 1ps

module pwm_channel_pair_allocator_unit_test;
  import pwmca_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE       = 30;
  localparam int          PHASE_ITEMS  = 250;
  localparam int          REPORT_MAX   = 10;
  localparam int unsigned DUTY_MAX     = (1 << DUTY_BITS) - 1;

  // Expected content of one result beat.
  typedef struct packed {
    status_e             status;
    logic [CHAN_W-1:0]   channel;
    logic [DUTY_W-1:0]   duty;
    logic                timer_setup;
    logic [FREQ_W-1:0]   timer_freq;
    logic                released;
    logic [CHAN_W-1:0]   released_channel;
  } outcome_t;

  // Tracks channel ownership and pair timers, and holds the outcomes still to be seen.
  class channel_binding_ledger;
    logic [PIN_W-1:0]  owner[NUM_CHANNELS];
    logic [FREQ_W-1:0] pair_freq[NUM_PAIRS];
    logic [FREQ_W-1:0] default_freq;
    outcome_t          awaited_beats[$];
    int unsigned       faults;

    function new();
      foreach (owner[i]) owner[i] = '0;
      foreach (pair_freq[i]) pair_freq[i] = '0;
      default_freq = RESET_FREQ;
      faults = 0;
    endfunction

    function void flag(string note);
      faults++;
      if (faults <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, note);
    endfunction

    function int owned_by(logic [PIN_W-1:0] pin);
      for (int i = 0; i < NUM_CHANNELS; i++)
        if (owner[i] == pin) return i;
      return -1;
    endfunction

    // Finds or takes a channel for the pin at the given frequency; -1 when none is left.
    function int bind_channel(logic [PIN_W-1:0] pin, logic [FREQ_W-1:0] freq, inout bit fresh);
      int held;
      int spare;
      int mate;
      held = owned_by(pin);
      spare = -1;
      if (held >= 0) return held;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mate = i ^ 1;
        if (owner[i] != '0) continue;
        if (mate < NUM_CHANNELS && owner[mate] != '0) begin
          if (pair_freq[i / 2] == freq) begin
            owner[i] = pin;
            return i;
          end
        end else if (spare < 0) begin
          spare = i & ~1;
        end
      end
      if (spare >= 0) begin
        owner[spare] = pin;
        pair_freq[spare / 2] = freq;
        fresh = 1'b1;
      end
      return spare;
    endfunction

    function void note_command(cmd_e cmd, logic [PIN_IN_W-1:0] pin, logic [FREQ_W-1:0] freq,
                               logic [LEVEL_W-1:0] level);
      outcome_t o;
      int       held;
      int       ch;
      bit       fresh;
      o = '0;
      fresh = 1'b0;
      if (pin == '0 || pin > MAX_PIN) begin
        o.status = ST_BAD_PIN;
        awaited_beats.push_back(o);
        return;
      end
      // A setup at a new frequency gives up the old channel before binding again.
      if (cmd == CMD_SETUP) begin
        held = owned_by(pin[PIN_W-1:0]);
        if (held >= 0 && pair_freq[held / 2] != freq) begin
          owner[held] = '0;
          o.released = 1'b1;
          o.released_channel = CHAN_W'(held);
        end
        void'(bind_channel(pin[PIN_W-1:0], freq, fresh));
      end
      ch = bind_channel(pin[PIN_W-1:0], default_freq, fresh);
      o.timer_setup = fresh;
      if (ch < 0) begin
        o.status = ST_NO_CHAN;
      end else begin
        o.status = ST_OK;
        o.channel = CHAN_W'(ch);
        o.duty = DUTY_W'((32'(level) * DUTY_MAX) / 32'(LEVEL_FULL));
        o.timer_freq = pair_freq[ch / 2];
      end
      awaited_beats.push_back(o);
    endfunction

    function void compare_field(string name, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
      if (want !== got)
        flag($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (awaited_beats.size() == 0) begin
        flag("result beat with no command outstanding");
        return;
      end
      want = awaited_beats.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("channel", 32'(want.channel), 32'(got.channel));
      compare_field("duty", 32'(want.duty), 32'(got.duty));
      compare_field("timer_setup", 32'(want.timer_setup), 32'(got.timer_setup));
      compare_field("timer_freq", want.timer_freq, got.timer_freq);
      compare_field("released", 32'(want.released), 32'(got.released));
      compare_field("released_channel", 32'(want.released_channel), 32'(got.released_channel));
    endfunction

    function void close();
      while (awaited_beats.size() != 0) begin
        void'(awaited_beats.pop_front());
        flag("result beat never arrived");
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_req;

  channel_binding_ledger ledger;

  pwmca_item_if   cmd_if ();
  pwmca_result_if res_if ();
  pwmca_cfg_if    cfg_if ();

  pwm_channel_pair_allocator_unit i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (cmd_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; none at all in a steady phase.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 45);
  endfunction

  // Offers one command beat and returns at the edge that accepts it; valid stays high.
  task automatic send_command(input cmd_e cmd, input logic [PIN_IN_W-1:0] pin,
                              input logic [FREQ_W-1:0] freq, input logic [LEVEL_W-1:0] level);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= cmd;
    cmd_if.pin   <= pin;
    cmd_if.freq  <= freq;
    cmd_if.level <= level;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Stops offering and waits until every outstanding result beat has been taken.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (ledger.awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_default_freq(input logic [FREQ_W-1:0] value);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random commands around a small set of frequencies, so that pairs get shared and reused.
  task automatic random_phase(input logic [FREQ_W-1:0] setting, input bit with_hold);
    logic [FREQ_W-1:0]   pool[4];
    logic [PIN_IN_W-1:0] pin;
    logic [FREQ_W-1:0]   freq;
    logic [LEVEL_W-1:0]  level;
    cmd_e                cmd;
    pool[0] = setting;
    pool[1] = $urandom_range(0, 3);
    pool[2] = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
    pool[3] = $urandom;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold && n == PHASE_ITEMS / 3) hold_req = 1'b1;
      cmd = ($urandom_range(0, 1) == 0) ? CMD_SETUP : CMD_DUTY;
      if ($urandom_range(0, 99) < 8)
        pin = ($urandom_range(0, 3) == 0) ? 8'd0 : PIN_IN_W'($urandom_range(MAX_PIN + 1, 255));
      else
        pin = PIN_IN_W'($urandom_range(1, MAX_PIN));
      if ($urandom_range(0, 99) < 75) freq = pool[$urandom_range(0, 3)];
      else freq = $urandom;
      case ($urandom_range(0, 9))
        0: level = '0;
        1: level = LEVEL_FULL;
        default: level = LEVEL_W'($urandom);
      endcase
      send_command(cmd, pin, freq, level);
    end
  endtask

  // Result side: ready drops at random, and once for a long hold when asked.
  initial begin : result_sink
    int span;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        span = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        span = idle_span();
      end
      if (span > 0) begin
        res_if.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Beat monitor: every accepted command is predicted, every result beat checked.
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready)
        ledger.note_command(cmd_e'(cmd_if.cmd), cmd_if.pin, cmd_if.freq, cmd_if.level);
      if (cfg_if.valid && cfg_if.ready)
        ledger.default_freq = cfg_if.data;
      if (res_if.valid && res_if.ready) begin
        got.status           = status_e'(res_if.status);
        got.channel          = res_if.channel;
        got.duty             = res_if.duty;
        got.timer_setup      = res_if.timer_setup;
        got.timer_freq       = res_if.timer_freq;
        got.released         = res_if.released;
        got.released_channel = res_if.released_channel;
        ledger.check_result(got);
      end
    end
  end

  // Watchdog: too long without any accepted beat ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence: reset, directed commands, then random phases at several default frequencies.
  initial begin : stimulus
    logic [FREQ_W-1:0] settings[7];
    ledger = new();
    steady = 1'b0;
    hold_req = 1'b0;
    rst_n        <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd   <= CMD_SETUP;
    cmd_if.pin   <= '0;
    cmd_if.freq  <= '0;
    cmd_if.level <= '0;
    res_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Invalid pins: zero, just above the range, and all ones.
    send_command(CMD_SETUP, 8'd0, 32'd1000, 8'd255);
    send_command(CMD_DUTY, 8'(MAX_PIN + 1), $urandom, 8'd17);
    send_command(CMD_SETUP, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // Fresh pair, a partner joining it, and a pair running at zero frequency.
    send_command(CMD_SETUP, 8'd1, 32'd1000, 8'd255);
    send_command(CMD_DUTY, 8'd2, $urandom, 8'd0);
    send_command(CMD_SETUP, 8'd3, 32'd0, 8'd128);
    send_command(CMD_SETUP, 8'd4, 32'd0, 8'd1);
    // Moving a pin to a new frequency releases its channel; the same frequency keeps it.
    send_command(CMD_SETUP, 8'd1, 32'd5000, 8'd254);
    send_command(CMD_SETUP, 8'(MAX_PIN), 32'hFFFF_FFFF, 8'd1);
    send_command(CMD_SETUP, 8'd1, 32'd5000, 8'd77);
    send_command(CMD_SETUP, 8'd5, 32'hFFFF_FFFF, 8'd200);
    // Fill every channel but the free one of the 5000 pair with duty writes at the default frequency.
    for (int p = 6; p <= 14; p++)
      send_command(CMD_DUTY, PIN_IN_W'(p), $urandom, LEVEL_W'($urandom));
    // No channel left, then the last free one taken at its pair frequency.
    send_command(CMD_DUTY, 8'd15, $urandom, 8'd99);
    send_command(CMD_SETUP, 8'd15, 32'd5000, 8'd99);
    send_command(CMD_SETUP, 8'd16, 32'd5000, 8'd3);
    // Release, failed bind at the new frequency, fallback to the default one.
    send_command(CMD_SETUP, 8'd2, 32'd42, 8'd64);
    // Release with no channel anywhere afterwards.
    send_command(CMD_SETUP, 8'd15, 32'd9, 8'd180);
    drain();

    settings[0] = RESET_FREQ;
    settings[1] = 32'hFFFF_FFFF;
    settings[2] = 32'd1;
    settings[3] = $urandom;
    settings[4] = 32'd1000;
    settings[5] = 32'd2;
    settings[6] = $urandom;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_default_freq(settings[ph]);
      steady = (ph == 4);
      random_phase(settings[ph], ph == 1);
      drain();
    end

    ledger.close();
    if (ledger.faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pwmca_pkg.sv
design/pwmca_if.sv
design/pwmca_ram.sv
design/pwmca_duty.sv
design/pwmca_ctrl.sv
design/pwm_channel_pair_allocator_unit.sv
test/pwm_channel_pair_allocator_unit_test.sv
